@@ hw/rtl/bra_pkg.sv @@
// Package for the bitmap run allocator: action codes, widths and the byte scan types.
// Has no dependencies. The interfaces, the scan step and the top level import it.
package bra_pkg;

	localparam int BYTE_W   = 8;
	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 10;
	localparam int LEN_W    = 11;
	localparam int START_W  = 10;
	localparam int BPOS_W   = 3;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [INDEX_W-1:0]  index_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [START_W-1:0]  start_t;
	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [BPOS_W-1:0]   bpos_t;

	localparam action_t ACT_FIND_RUN  = 3'd0;
	localparam action_t ACT_WRITE_BIT = 3'd1;
	localparam action_t ACT_TOGGLE    = 3'd2;
	localparam action_t ACT_TEST_TOG  = 3'd3;
	localparam action_t ACT_TEST      = 3'd4;
	localparam action_t ACT_CLEAR_ALL = 3'd5;

	// One byte of the map together with the free run that ends just before it and the run length sought.
	typedef struct packed {
		byte_t map_byte;
		len_t  run_count;
		len_t  run_len;
	} scan_in_t;

	typedef struct packed {
		logic  hit;
		bpos_t hit_pos;
		len_t  run_count;
	} scan_out_t;

endpackage

@@ hw/rtl/bra_if.sv @@
// Valid/ready channels of the bitmap run allocator: request and response.
// Depends on bra_pkg for the payload types.
interface bra_req_if import bra_pkg::*; ();
	logic    valid;
	logic    ready;
	action_t action;
	index_t  bit_index;
	logic    bit_value;
	len_t    run_length;

	modport source (output valid, action, bit_index, bit_value, run_length, input ready);
	modport sink (input valid, action, bit_index, bit_value, run_length, output ready);
endinterface

interface bra_rsp_if import bra_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   found;
	start_t run_start;
	logic   bit_state;

	modport source (output valid, found, run_start, bit_state, input ready);
	modport sink (input valid, found, run_start, bit_state, output ready);
endinterface

@@ hw/rtl/bra_map_mem.sv @@
// Slot map storage: one write port and one read port with registered read data.
// No dependencies.
module bra_map_mem #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/bra_scan_step.sv @@
// One step of the run search: walks the eight slots of a map byte.
// Depends on bra_pkg for the scan types.
module bra_scan_step import bra_pkg::*; (
	input  scan_in_t  scan_in,
	output scan_out_t scan_out
);

	always_comb begin
		len_t  cnt;
		logic  hit;
		bpos_t pos;
		cnt = scan_in.run_count;
		hit = 1'b0;
		pos = '0;
		for (int b = 0; b < BYTE_W; b++) begin
			if (!hit) begin
				if (scan_in.map_byte[b]) begin
					cnt = '0;
				end else begin
					cnt = cnt + len_t'(1);
					if (cnt == scan_in.run_len) begin
						hit = 1'b1;
						pos = bpos_t'(b);
					end
				end
			end
		end
		scan_out.hit       = hit;
		scan_out.hit_pos   = pos;
		scan_out.run_count = cnt;
	end

endmodule

@@ hw/rtl/bitmap_run_allocator.sv @@
// Top level of the bitmap run allocator: control sequencer around the slot map memory.
// Depends on bra_pkg, bra_if.sv, bra_map_mem and bra_scan_step.
//
//   channel | dir | payload                                  | transaction
//   req     | in  | action, bit_index, bit_value, run_length | valid & ready
//   rsp     | out | found, run_start, bit_state              | valid & ready
//
// A run search reads the map one byte a cycle through the single read port, stopping
// at the first hit or the last byte; a single-slot action reads its byte and handles
// it in S_BIT, then both finish in S_DONE.
// After reset, and for a clear_all transaction, a clearing pass writes zero to every
// byte, one a cycle; req is not ready meanwhile.
// One request is worked on at a time. A new request can be taken while the previous
// response still waits in the output register; a stall on rsp holds the block in
// its final state until the register is free.
module bitmap_run_allocator import bra_pkg::*; #(
	parameter int MAP_BYTES = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	bra_req_if.sink  req,
	bra_rsp_if.source rsp
);

	localparam int TOTAL_SLOTS = MAP_BYTES * BYTE_W;
	localparam int ADDR_W      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int IDX_W       = ADDR_W + BPOS_W;
	localparam int SUM_W       = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_BIT   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;

	// Work registers for the request in hand.
	logic [ADDR_W-1:0] addr_q;      // clearing pointer, scan byte or slot byte
	logic              clr_rsp_q;   // clearing pass was asked for by a transaction
	action_t           act_q;
	bpos_t             bpos_q;
	logic              bval_q;
	len_t              len_q;
	len_t              count_q;

	// Staged result, then the output register.
	logic   res_found_q;
	start_t res_start_q;
	logic   res_bit_q;
	logic   out_valid_q;
	logic   out_found_q;
	start_t out_start_q;
	logic   out_bit_q;

	logic              accept;
	logic              in_range;
	logic              len_ok;
	logic [ADDR_W+6:0] idx_byte_ext;
	logic [ADDR_W-1:0] idx_byte;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	byte_t             mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	byte_t             mem_rdata;

	scan_in_t          scan_in;
	scan_out_t         scan_out;
	logic [SUM_W-1:0]  start_full;

	logic  old_bit;
	logic  new_bit;
	byte_t bit_mask;
	logic  last_byte;
	logic  out_free;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign last_byte = (addr_q == LAST_ADDR);

	// Slot and length checks against the size of the map.
	assign in_range = (32'(req.bit_index) < TOTAL_SLOTS);
	assign len_ok   = (req.run_length != '0) && (32'(req.run_length) <= TOTAL_SLOTS);

	// Byte address of the slot; only meaningful when the slot lies inside the map.
	assign idx_byte_ext = {{ADDR_W{1'b0}}, req.bit_index[INDEX_W-1:BPOS_W]};
	assign idx_byte     = idx_byte_ext[ADDR_W-1:0];

	// Read port: the first byte of a search or the byte of a slot when a transaction
	// is taken, then the following byte during the scan so that one byte arrives
	// every cycle.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (accept) begin
			mem_re    = 1'b1;
			mem_raddr = (req.action == ACT_FIND_RUN) ? '0 : idx_byte;
		end else if (state_q == S_SCAN && !last_byte) begin
			mem_re    = 1'b1;
			mem_raddr = addr_q + ADDR_W'(1);
		end
	end

	// Bit read-modify-write on the byte that has just been read.
	assign bit_mask = byte_t'(1) << bpos_q;
	assign old_bit  = mem_rdata[bpos_q];
	always_comb begin
		unique case (act_q)
			ACT_WRITE_BIT: new_bit = bval_q;
			ACT_TOGGLE,
			ACT_TEST_TOG:  new_bit = !old_bit;
			default:       new_bit = old_bit;
		endcase
	end

	// Write port: the clearing pass, or the write back of a changed slot byte.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == S_BIT) begin
			mem_we    = (act_q == ACT_WRITE_BIT) || (act_q == ACT_TOGGLE) ||
			            (act_q == ACT_TEST_TOG);
			mem_wdata = (mem_rdata & ~bit_mask) | (new_bit ? bit_mask : '0);
		end
	end

	bra_map_mem #(
		.DEPTH  (MAP_BYTES),
		.ADDR_W (ADDR_W)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The search carries the length of the free run that reaches the end of the
	// bytes already seen. Skipping leading full bytes changes nothing, since a used
	// slot restarts the count anyway, so the scan simply starts at byte zero.
	assign scan_in.map_byte  = mem_rdata;
	assign scan_in.run_count = count_q;
	assign scan_in.run_len   = len_q;

	bra_scan_step u_scan (
		.scan_in  (scan_in),
		.scan_out (scan_out)
	);

	// First slot of the run: the hit slot plus one, less the length. Only the low
	// bits are reported.
	assign start_full = SUM_W'({addr_q, scan_out.hit_pos}) + SUM_W'(1) - SUM_W'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			clr_rsp_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A finished result enters the output register as soon as it is free;
			// otherwise a taken response empties it.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (req.action == ACT_FIND_RUN && len_ok) begin
							addr_q  <= '0;
							state_q <= S_SCAN;
						end else if ((req.action == ACT_WRITE_BIT ||
						              req.action == ACT_TOGGLE ||
						              req.action == ACT_TEST_TOG ||
						              req.action == ACT_TEST) && in_range) begin
							addr_q  <= idx_byte;
							state_q <= S_BIT;
						end else if (req.action == ACT_CLEAR_ALL) begin
							addr_q    <= '0;
							clr_rsp_q <= 1'b1;
							state_q   <= S_CLEAR;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_CLEAR: begin
					if (last_byte) begin
						clr_rsp_q <= 1'b0;
						state_q   <= clr_rsp_q ? S_DONE : S_IDLE;
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				S_SCAN: begin
					if (scan_out.hit || last_byte) begin
						state_q <= S_DONE;
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				S_BIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request fields, scan count, staged result and output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q       <= req.action;
			bpos_q      <= req.bit_index[BPOS_W-1:0];
			bval_q      <= req.bit_value;
			len_q       <= req.run_length;
			count_q     <= '0;
			res_found_q <= 1'b0;
			res_start_q <= '0;
			res_bit_q   <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			count_q <= scan_out.run_count;
			if (scan_out.hit) begin
				res_found_q <= 1'b1;
				res_start_q <= start_full[START_W-1:0];
			end
		end
		if (state_q == S_BIT) begin
			res_bit_q <= (act_q == ACT_WRITE_BIT) ? 1'b0 :
			             (act_q == ACT_TOGGLE) ? new_bit : old_bit;
		end
		if (state_q == S_DONE && out_free) begin
			out_found_q <= res_found_q;
			out_start_q <= res_start_q;
			out_bit_q   <= res_bit_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.found     = out_found_q;
	assign rsp.run_start = out_start_q;
	assign rsp.bit_state = out_bit_q;

endmodule

@@ dv/bitmap_run_allocator_checker.sv @@
// Checker for the bitmap run allocator: watches the req and rsp channels, predicts every response.
// Depends on bra_pkg and the channel interfaces in bra_if.sv.
module bitmap_run_allocator_checker import bra_pkg::*; #(
	parameter int MAP_BYTES = 128
) (
	input  logic clk,
	input  logic arst_n,
	bra_req_if   req,
	bra_rsp_if   rsp,
	output int   mismatches,
	output int   owed
);

	localparam int SLOTS      = MAP_BYTES * 8;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic   found;
		start_t run_start;
		logic   bit_state;
	} alloc_reply_t;

	// Slot i of the map is bit i of this vector; 1 means used.
	logic [SLOTS-1:0] slot_used;
	alloc_reply_t     replies_due[$];

	// Applies one request to the shadow map and returns the response it should give.
	function automatic alloc_reply_t apply_action(action_t act, index_t idx, logic val, len_t len);
		alloc_reply_t r;
		int           run;
		int           slot;
		r    = '0;
		run  = 0;
		slot = int'(idx);
		case (act)
			ACT_FIND_RUN: begin
				// Lowest run of free slots that lies wholly inside the map.
				if (len != '0 && int'(len) <= SLOTS) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_used[i])
							run = 0;
						else
							run++;
						if (run == int'(len)) begin
							r.found     = 1'b1;
							r.run_start = start_t'(i + 1 - run);
							break;
						end
					end
				end
			end
			ACT_WRITE_BIT: begin
				if (slot < SLOTS)
					slot_used[slot] = val;
			end
			ACT_TOGGLE: begin
				if (slot < SLOTS) begin
					slot_used[slot] = ~slot_used[slot];
					r.bit_state     = slot_used[slot];
				end
			end
			ACT_TEST_TOG: begin
				if (slot < SLOTS) begin
					r.bit_state     = slot_used[slot];
					slot_used[slot] = ~slot_used[slot];
				end
			end
			ACT_TEST: begin
				if (slot < SLOTS)
					r.bit_state = slot_used[slot];
			end
			ACT_CLEAR_ALL: begin
				slot_used = '0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_reply_t got;
		alloc_reply_t want;
		if (!arst_n) begin
			slot_used = '0;
			replies_due.delete();
			mismatches = 0;
			owed       = 0;
		end else begin
			// Responses are checked before the request of the same edge is predicted.
			if (rsp.valid && rsp.ready) begin
				got.found     = rsp.found;
				got.run_start = rsp.run_start;
				got.bit_state = rsp.bit_state;
				if (replies_due.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("response with none outstanding: found %0b run_start %0d bit_state %0b",
							got.found, got.run_start, got.bit_state);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (got.found !== want.found || got.run_start !== want.run_start ||
							got.bit_state !== want.bit_state) begin
						if (mismatches < REPORT_MAX)
							$display("response mismatch: found %0b/%0b run_start %0d/%0d bit_state %0b/%0b (expected/actual)",
								want.found, got.found, want.run_start, got.run_start,
								want.bit_state, got.bit_state);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(apply_action(req.action, req.bit_index, req.bit_value,
					req.run_length));
			owed = replies_due.size();
		end
	end

endmodule

@@ dv/bitmap_run_allocator_tb.sv @@
// Top of the bitmap run allocator testbench: clock, reset, request stimulus and response stalls.
// Depends on bra_pkg, bra_if.sv, the block itself and bitmap_run_allocator_checker.
module bitmap_run_allocator_tb;
	import bra_pkg::*;

	localparam int MAP_BYTES      = 128;
	localparam int SLOTS          = MAP_BYTES * 8;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS   = 1100;
	localparam int PAUSE_EVERY    = 250;
	// Searches and clearing passes are bounded by the size of the map, and idle spells on either
	// side are short, so a quiet spell this long means the block has hung.
	localparam int IDLE_LIMIT     = 4000;
	localparam int TAIL_CYCLES    = 8;

	logic clk;
	logic arst_n;
	logic calm;
	logic req_took;
	logic rsp_took;
	int   requests_sent;
	int   mismatches;
	int   replies_owed;

	bra_req_if req_ch ();
	bra_rsp_if rsp_ch ();

	bitmap_run_allocator #(
		.MAP_BYTES(MAP_BYTES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	bitmap_run_allocator_checker #(
		.MAP_BYTES(MAP_BYTES)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.mismatches(mismatches),
		.owed      (replies_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Registered record of the transactions at each rising edge. The stimulus reads these at the
	// falling edge, long after the edge has settled, so the handshake is seen without any race.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_took <= 1'b0;
			rsp_took <= 1'b0;
		end else begin
			req_took <= req_ch.valid && req_ch.ready;
			rsp_took <= rsp_ch.valid && rsp_ch.ready;
		end
	end

	// Run lengths are mostly short so that searches hit the gaps left in a busy map, with some long
	// ones, the whole map, zero and lengths past the end of the map mixed in.
	function automatic len_t pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return '0;
		else if (r < 8)
			return len_t'($urandom_range(2047, SLOTS + 1));
		else if (r < 14)
			return len_t'($urandom_range(SLOTS, 200));
		else if (r < 30)
			return len_t'($urandom_range(199, 17));
		else
			return len_t'($urandom_range(16, 1));
	endfunction

	// Presents one request and returns at the falling edge after it has been accepted. Valid stays
	// high from one request to the next unless the sender idles, which outside the calm stretch it
	// does with a chance of seven in a hundred each cycle, so back-to-back traffic is covered.
	task automatic send(input action_t act, input index_t idx, input logic val, input len_t len);
		while (!calm && $urandom_range(99) < 7) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.action     = act;
		req_ch.bit_index  = idx;
		req_ch.bit_value  = val;
		req_ch.run_length = len;
		do
			@(negedge clk);
		while (!req_took);
		requests_sent++;
	endtask

	// Holds the sender back until every outstanding response has been returned.
	task automatic drain();
		req_ch.valid = 1'b0;
		while (replies_owed != 0)
			@(negedge clk);
	endtask

	// Response side: not ready at random, with a chance of seven in a hundred, except during the
	// calm stretch, where the channel is always ready.
	initial begin : rsp_stalls
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= calm || ($urandom_range(99) >= 7);
		end
	end

	// Ends the run if no transaction on either channel has happened for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(negedge clk);
			if (req_took || rsp_took)
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int      lo;
		int      span;
		int      base;
		int      burst;
		int      pick;
		int      op;
		int      next_pause;
		action_t act;
		index_t  idx;

		arst_n            = 1'b0;
		calm              = 1'b0;
		requests_sent     = 0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_TEST;
		req_ch.bit_index  = '0;
		req_ch.bit_value  = 1'b0;
		req_ch.run_length = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. On the empty map a zero length and anything past the map are not found,
		// while a run of the whole map starts at slot zero.
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(0));
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(SLOTS));
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(SLOTS + 1));
		send(ACT_FIND_RUN, '1, 1'b1, '1);
		// The last slot: toggle gives the new value, test-and-toggle the old one.
		send(ACT_TEST, index_t'(SLOTS - 1), 1'b1, '1);
		send(ACT_TOGGLE, index_t'(SLOTS - 1), 1'b0, '0);
		send(ACT_TEST_TOG, index_t'(SLOTS - 1), 1'b1, '1);
		// Filling the first byte makes the search skip a completely used byte.
		for (int i = 0; i < 8; i++)
			send(ACT_WRITE_BIT, index_t'(i), 1'b1, '0);
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(1));
		// With slot 511 used the map holds runs of 503 and 512 slots, the second ending exactly
		// at the end of the map, so a run one longer must not be found.
		send(ACT_WRITE_BIT, index_t'(511), 1'b1, '0);
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(503));
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(504));
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(512));
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(513));
		send(ACT_WRITE_BIT, '0, 1'b0, '0);
		send(ACT_TEST, '0, 1'b0, '0);
		send(ACT_CLEAR_ALL, '1, 1'b1, '1);
		send(ACT_FIND_RUN, '0, 1'b0, len_t'(SLOTS));
		drain();

		// Random part. Most traffic is bursts of mixed actions concentrated on a window of 64
		// slots, so that whole bytes fill up and the search has gaps to find. Some episodes write a
		// stretch of used slots and then search, and an occasional clear starts the map afresh.
		next_pause = requests_sent + PAUSE_EVERY;
		while (requests_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			calm = requests_sent >= 500 && requests_sent < 760;
			if (requests_sent >= next_pause) begin
				drain();
				next_pause += PAUSE_EVERY;
			end
			pick = $urandom_range(99);
			if (pick < 4) begin
				send(ACT_CLEAR_ALL, index_t'($urandom), 1'($urandom_range(1)), len_t'($urandom));
			end else if (pick < 24) begin
				lo   = $urandom_range(SLOTS - 1);
				span = $urandom_range(64, 1);
				for (int i = 0; i < span && lo + i < SLOTS; i++)
					send(ACT_WRITE_BIT, index_t'(lo + i), 1'b1, len_t'($urandom));
				send(ACT_FIND_RUN, index_t'($urandom), 1'($urandom_range(1)), pick_len());
			end else begin
				base  = $urandom_range(SLOTS - 64);
				burst = $urandom_range(30, 8);
				repeat (burst) begin
					op  = $urandom_range(99);
					idx = ($urandom_range(3) != 0) ? index_t'(base + $urandom_range(63))
						: index_t'($urandom);
					if (op < 30)
						act = ACT_FIND_RUN;
					else if (op < 65)
						act = ACT_WRITE_BIT;
					else if (op < 77)
						act = ACT_TOGGLE;
					else if (op < 89)
						act = ACT_TEST_TOG;
					else
						act = ACT_TEST;
					// Writes lean towards marking slots used so that the map grows busy.
					send(act, idx, $urandom_range(99) < 65, pick_len());
				end
			end
		end

		calm = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && replies_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/bra_pkg.sv
hw/rtl/bra_if.sv
hw/rtl/bra_map_mem.sv
hw/rtl/bra_scan_step.sv
hw/rtl/bitmap_run_allocator.sv
dv/bitmap_run_allocator_checker.sv
dv/bitmap_run_allocator_tb.sv
